FILE: rtl/rainbow_pixel_pattern_generator_assert.svh
// Assertion macros for the rainbow pixel pattern generator checker.
// Needs signals named clock and reset in the module that expands them.
`ifndef RAINBOW_PIXEL_PATTERN_GENERATOR_ASSERT_SVH
`define RAINBOW_PIXEL_PATTERN_GENERATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RPP_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rpp assertion failed");

// Next-cycle implication, disabled during reset.
`define RPP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rpp assertion failed");

`endif

FILE: rtl/rpp_pkg.sv
// Package for the rainbow pixel pattern generator: widths, reset values,
// register indexes and the colour wheel phase type. No dependencies.
`default_nettype none

package rpp_pkg;

   localparam int COLOUR_W   = 8;
   localparam int OUT_COL_W  = 6;
   localparam int PIX_W      = 10;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 10;

   localparam logic [COLOUR_W-1:0] BRIGHT_LIMIT_RESET = 8'd32;
   localparam logic [PIX_W-1:0]    NUM_PIXELS_RESET   = 10'd64;
   localparam logic [COLOUR_W-1:0] PEAK_RESET         = BRIGHT_LIMIT_RESET - 8'd1;

   localparam logic [CSR_IDX_W-1:0] CSR_BRIGHT_LIMIT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_PIXELS   = 1'd1;

   typedef enum logic [2:0] {
      PH_GREEN_UP   = 3'd0,
      PH_RED_DOWN   = 3'd1,
      PH_BLUE_UP    = 3'd2,
      PH_GREEN_DOWN = 3'd3,
      PH_RED_UP     = 3'd4,
      PH_BLUE_DOWN  = 3'd5
   } phase_type;

endpackage

`default_nettype wire

FILE: rtl/rpp_channels.sv
// Valid/ready channel interfaces for the rainbow pixel pattern generator:
// pixel request, pixel response and register write. Uses rpp_pkg.
`default_nettype none

interface rpp_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
   modport monitor (input valid, input restart, input ready);
endinterface

interface rpp_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [rpp_pkg::OUT_COL_W-1:0] red;
   logic [rpp_pkg::OUT_COL_W-1:0] green;
   logic [rpp_pkg::OUT_COL_W-1:0] blue;
   logic [rpp_pkg::PIX_W-1:0]     pixel_index;
   logic                          frame_end;

   modport source (output valid, output red, output green, output blue,
                   output pixel_index, output frame_end, input ready);
   modport sink (input valid, input red, input green, input blue,
                 input pixel_index, input frame_end, output ready);
   modport monitor (input valid, input red, input green, input blue,
                    input pixel_index, input frame_end, input ready);
endinterface

interface rpp_csr_if;
   logic                           valid;
   logic                           ready;
   logic [rpp_pkg::CSR_IDX_W-1:0]  idx;
   logic [rpp_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, output idx, output data, input ready);
   modport sink (input valid, input idx, input data, output ready);
   modport monitor (input valid, input idx, input data, input ready);
endinterface

`default_nettype wire

FILE: rtl/rainbow_pixel_pattern_generator.sv
// Rainbow pixel pattern generator. A pixel appears on rsp in the cycle after its request
// transaction. Throughput: one pixel per cycle while rsp is not stalled, set by the
// single colour step (one 8-bit add/subtract and compare) between the request and the
// response register. The response register frees itself in the cycle it is taken, so
// req stalls only while rsp is stalled. Synchronous active-high reset: brightness
// limit 32, 64 pixels, red at peak 31, other colours and phase zero, counter zero, no
// response pending. Depends on rpp_pkg and the interfaces in rpp_channels.sv.
`default_nettype none

module rainbow_pixel_pattern_generator (
   input  wire           clock,
   input  wire           reset,
   rpp_req_if.sink       req_chan,
   rpp_rsp_if.source     rsp_chan,
   rpp_csr_if.sink       csr_chan
);

   // configuration registers
   logic [rpp_pkg::COLOUR_W-1:0] bright_limit_ff;
   logic [rpp_pkg::PIX_W-1:0]    num_pixels_ff;

   // working and saved animation state, pixel counter
   logic [rpp_pkg::COLOUR_W-1:0] work_red_ff, work_green_ff, work_blue_ff;
   logic [rpp_pkg::COLOUR_W-1:0] work_red_in, work_green_in, work_blue_in;
   rpp_pkg::phase_type           work_phase_ff, work_phase_in;
   logic [rpp_pkg::COLOUR_W-1:0] saved_red_ff, saved_green_ff, saved_blue_ff;
   logic [rpp_pkg::COLOUR_W-1:0] saved_red_in, saved_green_in, saved_blue_in;
   rpp_pkg::phase_type           saved_phase_ff, saved_phase_in;
   logic [rpp_pkg::PIX_W-1:0]    pix_cnt_ff, pix_cnt_in;

   // response register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [rpp_pkg::OUT_COL_W-1:0] rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic [rpp_pkg::PIX_W-1:0]     rsp_index_ff;
   logic                          rsp_last_ff;

   // combinational pixel datapath
   logic                          req_fire;
   logic [rpp_pkg::COLOUR_W-1:0]  peak;
   logic [rpp_pkg::PIX_W-1:0]     last_index;
   logic [rpp_pkg::COLOUR_W-1:0]  base_red, base_green, base_blue;
   logic [rpp_pkg::COLOUR_W-1:0]  sv_red, sv_green, sv_blue;
   rpp_pkg::phase_type            base_phase, sv_phase;
   logic [rpp_pkg::PIX_W-1:0]     idx;
   logic [rpp_pkg::COLOUR_W-1:0]  cur_red, cur_green, cur_blue;
   rpp_pkg::phase_type            cur_phase;
   logic                          is_last;

   // Request taken whenever the response register is empty or being drained.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign peak       = bright_limit_ff - 8'd1;
   assign last_index = num_pixels_ff - 10'd1;

   // Restart reload, then restore from the saved copy at the frame start.
   always_comb begin
      if (req_chan.restart) begin
         base_red   = peak;
         base_green = '0;
         base_blue  = '0;
         base_phase = rpp_pkg::PH_GREEN_UP;
         sv_red     = peak;
         sv_green   = '0;
         sv_blue    = '0;
         sv_phase   = rpp_pkg::PH_GREEN_UP;
         idx        = '0;
      end else begin
         base_red   = work_red_ff;
         base_green = work_green_ff;
         base_blue  = work_blue_ff;
         base_phase = work_phase_ff;
         sv_red     = saved_red_ff;
         sv_green   = saved_green_ff;
         sv_blue    = saved_blue_ff;
         sv_phase   = saved_phase_ff;
         idx        = pix_cnt_ff;
      end
      if (idx == '0) begin
         cur_red   = sv_red;
         cur_green = sv_green;
         cur_blue  = sv_blue;
         cur_phase = sv_phase;
      end else begin
         cur_red   = base_red;
         cur_green = base_green;
         cur_blue  = base_blue;
         cur_phase = base_phase;
      end
      is_last = (idx == last_index);
      // pixel 1 snapshots the pre-step state for the next frame
      if (idx == 10'd1) begin
         saved_red_in   = cur_red;
         saved_green_in = cur_green;
         saved_blue_in  = cur_blue;
         saved_phase_in = cur_phase;
      end else begin
         saved_red_in   = sv_red;
         saved_green_in = sv_green;
         saved_blue_in  = sv_blue;
         saved_phase_in = sv_phase;
      end
      pix_cnt_in = is_last ? '0 : idx + 10'd1;
   end

   // Colour step of the wheel: one component moves per pixel.
   always_comb begin
      work_red_in   = cur_red;
      work_green_in = cur_green;
      work_blue_in  = cur_blue;
      case (cur_phase)
         rpp_pkg::PH_GREEN_UP:   work_green_in = cur_green + 8'd1;
         rpp_pkg::PH_RED_DOWN:   work_red_in   = cur_red - 8'd1;
         rpp_pkg::PH_BLUE_UP:    work_blue_in  = cur_blue + 8'd1;
         rpp_pkg::PH_GREEN_DOWN: work_green_in = cur_green - 8'd1;
         rpp_pkg::PH_RED_UP:     work_red_in   = cur_red + 8'd1;
         rpp_pkg::PH_BLUE_DOWN:  work_blue_in  = cur_blue - 8'd1;
         default: ;
      endcase
   end

   // Next phase: rising legs end at the peak, falling legs at zero.
   always_comb begin
      work_phase_in = cur_phase;
      case (cur_phase)
         rpp_pkg::PH_GREEN_UP:
            if (work_green_in >= peak) work_phase_in = rpp_pkg::PH_RED_DOWN;
         rpp_pkg::PH_RED_DOWN:
            if (work_red_in == '0) work_phase_in = rpp_pkg::PH_BLUE_UP;
         rpp_pkg::PH_BLUE_UP:
            if (work_blue_in >= peak) work_phase_in = rpp_pkg::PH_GREEN_DOWN;
         rpp_pkg::PH_GREEN_DOWN:
            if (work_green_in == '0) work_phase_in = rpp_pkg::PH_RED_UP;
         rpp_pkg::PH_RED_UP:
            if (work_red_in >= peak) work_phase_in = rpp_pkg::PH_BLUE_DOWN;
         rpp_pkg::PH_BLUE_DOWN:
            if (work_blue_in == '0) work_phase_in = rpp_pkg::PH_GREEN_UP;
         default: ;
      endcase
   end

   assign rsp_valid_in = req_fire || (rsp_valid_ff && !rsp_chan.ready);

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         bright_limit_ff <= rpp_pkg::BRIGHT_LIMIT_RESET;
         num_pixels_ff   <= rpp_pkg::NUM_PIXELS_RESET;
      end else if (csr_chan.valid) begin
         case (csr_chan.idx)
            rpp_pkg::CSR_BRIGHT_LIMIT: bright_limit_ff <= csr_chan.data[rpp_pkg::COLOUR_W-1:0];
            rpp_pkg::CSR_NUM_PIXELS:   num_pixels_ff   <= csr_chan.data[rpp_pkg::PIX_W-1:0];
            default: ;
         endcase
      end
   end

   // Animation state, advanced once per request transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         work_red_ff    <= rpp_pkg::PEAK_RESET;
         work_green_ff  <= '0;
         work_blue_ff   <= '0;
         work_phase_ff  <= rpp_pkg::PH_GREEN_UP;
         saved_red_ff   <= rpp_pkg::PEAK_RESET;
         saved_green_ff <= '0;
         saved_blue_ff  <= '0;
         saved_phase_ff <= rpp_pkg::PH_GREEN_UP;
         pix_cnt_ff     <= '0;
      end else if (req_fire) begin
         work_red_ff    <= work_red_in;
         work_green_ff  <= work_green_in;
         work_blue_ff   <= work_blue_in;
         work_phase_ff  <= work_phase_in;
         saved_red_ff   <= saved_red_in;
         saved_green_ff <= saved_green_in;
         saved_blue_ff  <= saved_blue_in;
         saved_phase_ff <= saved_phase_in;
         pix_cnt_ff     <= pix_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: colour divided by four, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_red_ff   <= cur_red[rpp_pkg::COLOUR_W-1:2];
         rsp_green_ff <= cur_green[rpp_pkg::COLOUR_W-1:2];
         rsp_blue_ff  <= cur_blue[rpp_pkg::COLOUR_W-1:2];
         rsp_index_ff <= idx;
         rsp_last_ff  <= is_last;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.red         = rsp_red_ff;
   assign rsp_chan.green       = rsp_green_ff;
   assign rsp_chan.blue        = rsp_blue_ff;
   assign rsp_chan.pixel_index = rsp_index_ff;
   assign rsp_chan.frame_end   = rsp_last_ff;

endmodule

`default_nettype wire

FILE: rtl/rpp_checker.sv
// Port-level checker for the rainbow pixel pattern generator and its bind.
// Depends on rpp_channels.sv and rainbow_pixel_pattern_generator_assert.svh.
`default_nettype none
`include "rainbow_pixel_pattern_generator_assert.svh"

module rpp_checker (
   input  wire       clock,
   input  wire       reset,
   rpp_req_if.sink   req_mon,
   rpp_rsp_if.source rsp_mon
);

   logic                                         req_fire;
   logic [3*rpp_pkg::OUT_COL_W+rpp_pkg::PIX_W:0] rsp_payload;

   assign req_fire    = req_mon.valid && req_mon.ready;
   assign rsp_payload = {rsp_mon.red, rsp_mon.green, rsp_mon.blue,
                         rsp_mon.pixel_index, rsp_mon.frame_end};

   // stalled response holds
   `RPP_ASSERT_NEXT(a_rsp_hold, rsp_mon.valid && !rsp_mon.ready, rsp_mon.valid && $stable(rsp_payload))

   // a free response slot never blocks a request
   `RPP_ASSERT_NOW(a_req_ready, !rsp_mon.valid || rsp_mon.ready, req_mon.ready)

   // every request transaction yields a response next cycle
   `RPP_ASSERT_NEXT(a_req_to_rsp, req_fire, rsp_mon.valid)

   // restart always begins a frame at pixel zero
   `RPP_ASSERT_NEXT(a_restart_idx, req_fire && req_mon.restart, rsp_mon.pixel_index == '0)

endmodule

bind rainbow_pixel_pattern_generator rpp_checker u_rpp_checker (
   .clock   (clock),
   .reset   (reset),
   .req_mon (req_chan),
   .rsp_mon (rsp_chan)
);

`default_nettype wire
